// ===== hw/rtl/mhid_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-heap unit package
// Result status codes and operation codes shared by the heap unit and its users.
// ----------------------------------------------------------------------------
package mhid_pkg;

  // Result status of one item.
  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  // Operation codes of an input item.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

endpackage

// ===== hw/rtl/min_heap_insert_delete_unit.sv =====
// ----------------------------------------------------------------------------
// Min-heap insert/delete unit
// Binary min-heap of signed keys kept in one synchronous memory.
// ----------------------------------------------------------------------------
// Accept to result strobe: a full-heap insert, an empty-heap delete or an
// insert into an empty heap is answered straight from idle; other inserts
// compare with each parent in turn and write the key where the climb stops.
// Deletes scan the keys, fetch the last entry and sift it up or down by level.
// One item at a time: busy is high until the result cycle; results cannot be
// stalled. Reset empties the heap at once; memory contents are not cleared.
module min_heap_insert_delete_unit #(
  parameter int HEAP_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                operation_i,
  input  logic signed [31:0]  key_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [8:0]          element_count_o,
  output logic signed [31:0]  smallest_key_o
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int XW = AW + 2;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_UP_RD    = 4'd1;
  localparam logic [3:0] ST_UP_CMP   = 4'd2;
  localparam logic [3:0] ST_WR_FIN   = 4'd3;
  localparam logic [3:0] ST_SCAN_RD  = 4'd4;
  localparam logic [3:0] ST_SCAN_CMP = 4'd5;
  localparam logic [3:0] ST_LAST_RD  = 4'd6;
  localparam logic [3:0] ST_LAST_CAP = 4'd7;
  localparam logic [3:0] ST_DN_RDL   = 4'd8;
  localparam logic [3:0] ST_DN_RDR   = 4'd9;
  localparam logic [3:0] ST_DN_CMP   = 4'd10;

  logic [3:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic signed [31:0] mk_q, mk_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] lval_q, lval_d;
  logic signed [31:0] root_q;
  logic               first_q, first_d;
  logic               done_q, done_d;
  logic [1:0]         status_q, status_d;

  // Heap storage and its port signals.
  logic signed [31:0] mem [HEAP_DEPTH];
  logic signed [31:0] rdata_q;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  // Index arithmetic around the current position.
  logic [AW-1:0] parent;
  logic [XW-1:0] left_x, right_x;
  logic          left_ok, right_ok;
  logic [AW-1:0] left_a, right_a;

  assign parent   = (pos_q - AW'(1)) >> 1;
  assign left_x   = {1'b0, pos_q, 1'b1};
  assign right_x  = left_x + XW'(1);
  assign left_ok  = left_x < XW'(count_q);
  assign right_ok = right_x < XW'(count_q);
  assign left_a   = left_x[AW-1:0];
  assign right_a  = right_x[AW-1:0];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    mk_d     = mk_q;
    key_d    = key_q;
    lval_d   = lval_q;
    first_d  = first_q;
    done_d   = 1'b0;
    status_d = status_q;
    rd_en    = 1'b0;
    rd_addr  = pos_q;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = mk_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          key_d = key_i;
          if (operation_i == mhid_pkg::OP_INSERT) begin
            if (count_q >= CW'(HEAP_DEPTH)) begin
              done_d   = 1'b1;
              status_d = mhid_pkg::STATUS_FULL;
            end else begin
              count_d = count_q + CW'(1);
              pos_d   = count_q[AW-1:0];
              mk_d    = key_i;
              first_d = 1'b0;
              if (count_q == '0) begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                wr_data  = key_i;
                done_d   = 1'b1;
                status_d = mhid_pkg::STATUS_DONE;
              end else begin
                state_d = ST_UP_RD;
              end
            end
          end else begin
            if (count_q == '0) begin
              done_d   = 1'b1;
              status_d = mhid_pkg::STATUS_NOT_FOUND;
            end else begin
              pos_d   = '0;
              state_d = ST_SCAN_RD;
            end
          end
        end
      end
      ST_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = parent;
        state_d = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        first_d = 1'b0;
        if (mk_q < rdata_q) begin
          // Move the parent down into the hole and climb.
          wr_en   = 1'b1;
          wr_data = rdata_q;
          pos_d   = parent;
          state_d = (parent == '0) ? ST_WR_FIN : ST_UP_RD;
        end else if (first_q) begin
          state_d = ST_DN_RDL;
        end else begin
          wr_en    = 1'b1;
          done_d   = 1'b1;
          status_d = mhid_pkg::STATUS_DONE;
          state_d  = ST_IDLE;
        end
      end
      ST_WR_FIN: begin
        wr_en    = 1'b1;
        done_d   = 1'b1;
        status_d = mhid_pkg::STATUS_DONE;
        state_d  = ST_IDLE;
      end
      ST_SCAN_RD: begin
        rd_en   = 1'b1;
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (rdata_q == key_q) begin
          count_d = count_q - CW'(1);
          if (CW'(pos_q) == count_q - CW'(1)) begin
            done_d   = 1'b1;
            status_d = mhid_pkg::STATUS_DONE;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_LAST_RD;
          end
        end else if (CW'(pos_q) + CW'(1) == count_q) begin
          done_d   = 1'b1;
          status_d = mhid_pkg::STATUS_NOT_FOUND;
          state_d  = ST_IDLE;
        end else begin
          pos_d   = pos_q + AW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_LAST_RD: begin
        // The count was already reduced, so it addresses the last entry.
        rd_en   = 1'b1;
        rd_addr = count_q[AW-1:0];
        state_d = ST_LAST_CAP;
      end
      ST_LAST_CAP: begin
        mk_d = rdata_q;
        if (pos_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = parent;
          first_d = 1'b1;
          state_d = ST_UP_CMP;
        end else begin
          state_d = ST_DN_RDL;
        end
      end
      ST_DN_RDL: begin
        if (left_ok) begin
          rd_en   = 1'b1;
          rd_addr = left_a;
          state_d = ST_DN_RDR;
        end else begin
          wr_en    = 1'b1;
          done_d   = 1'b1;
          status_d = mhid_pkg::STATUS_DONE;
          state_d  = ST_IDLE;
        end
      end
      ST_DN_RDR: begin
        lval_d  = rdata_q;
        rd_en   = right_ok;
        rd_addr = right_a;
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        // Smallest of entry and children; ties keep the entry or the left child.
        if (right_ok && (rdata_q < lval_q) && (rdata_q < mk_q)) begin
          wr_en   = 1'b1;
          wr_data = rdata_q;
          pos_d   = right_a;
          state_d = ST_DN_RDL;
        end else if (lval_q < mk_q) begin
          wr_en   = 1'b1;
          wr_data = lval_q;
          pos_d   = left_a;
          state_d = ST_DN_RDL;
        end else begin
          wr_en    = 1'b1;
          done_d   = 1'b1;
          status_d = mhid_pkg::STATUS_DONE;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Heap memory with one registered read port and one write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Root copy and payload registers.
  always_ff @(posedge clk_i) begin
    if (wr_en && wr_addr == '0) begin
      root_q <= wr_data;
    end
    pos_q    <= pos_d;
    mk_q     <= mk_d;
    key_q    <= key_d;
    lval_q   <= lval_d;
    status_q <= status_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      first_q <= first_d;
      done_q  <= done_d;
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign element_count_o = 9'(count_q);
  assign smallest_key_o  = (count_q != '0) ? root_q : 32'sd0;

endmodule
